// ===== hdl/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam logic [15:0] BAD_UNIT       = 16'hFFFC;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_STOP_AT_NUL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    STOP_CLEAN      = 2'd0,
    STOP_INCOMPLETE = 2'd1,
    STOP_CAPACITY   = 2'd2,
    STOP_NUL        = 2'd3
  } stop_e;

  typedef struct packed {
    logic        stop_at_nul;
    logic [15:0] unit_capacity;
  } cfg_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_summary;
    stop_e       stop_reason;
    logic [31:0] bytes_consumed;
    logic [15:0] units_written;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// ===== hdl/u8u16_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8u16_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_summary;
  logic [1:0]  stop_reason;
  logic [31:0] bytes_consumed;
  logic [15:0] units_written;
  logic        run_end;

  modport source (output valid, output code_unit, output is_summary, output stop_reason,
                  output bytes_consumed, output units_written, output run_end,
                  input ready);
  modport sink   (input valid, input code_unit, input is_summary, input stop_reason,
                  input bytes_consumed, input units_written, input run_end,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/utf8_to_utf16_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream in, UTF-16 code units and per-buffer summaries out.
//
// in_i carries one UTF-8 byte per transfer; last_byte closes a buffer.
// out_o carries results: decoded units, NUL terminators and, for the last
// byte of each buffer, a summary with stop reason and saturating counts.
// run_end marks the last result produced by a byte.
// The cfg port writes stop_at_nul (index 0) and unit_capacity (index 1);
// write only while the block is idle.
// A byte is registered on acceptance and decoded into the result queue once
// the queue has room; its results leave on out_o behind any older ones. One
// byte per cycle is taken as long as the 4-entry result queue has room for
// two results; a byte giving two results (unit plus summary) needs two
// output transfers, so output bandwidth sets the rate.
// When the receiver stalls, the queue fills and in_i.ready drops.
// Reset empties the queue, clears all buffer state and sets stop_at_nul to
// 0 and unit_capacity to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  u8u16_byte_if.sink                     in_i,
  u8u16_result_if.source                 out_o,
  input  wire                            cfg_we_i,
  input  wire [u8u16_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [u8u16_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import u8u16_pkg::*;

  cfg_t       cfg_q;
  logic       in_v_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       step, space, in_take;
  push_t      push;
  result_t    head;

  assign step     = in_v_q && space;
  assign in_i.ready = !in_v_q || step;
  assign in_take  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_at_nul   <= 1'b0;
      cfg_q.unit_capacity <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STOP_AT_NUL:   cfg_q.stop_at_nul   <= cfg_data_i[0];
        CFG_UNIT_CAPACITY: cfg_q.unit_capacity <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_take) begin
      in_v_q <= 1'b1;
    end else if (step) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  u8u16_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .push_o      (push)
  );

  u8u16_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.code_unit      = head.code_unit;
  assign out_o.is_summary     = head.is_summary;
  assign out_o.stop_reason    = head.stop_reason;
  assign out_o.bytes_consumed = head.bytes_consumed;
  assign out_o.units_written  = head.units_written;
  assign out_o.run_end        = head.run_end;

endmodule

`default_nettype wire

// ===== hdl/u8u16_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_core
// Per-byte decode step: sequence state, counters and up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  u8u16_pkg::cfg_t       cfg_i,
  input  wire                   step_i,
  input  wire  [7:0]            data_byte_i,
  input  wire                   last_byte_i,
  output u8u16_pkg::push_t      push_o
);
  import u8u16_pkg::*;

  logic        halted_q, halted_d;
  logic [2:0]  left_q, left_d;
  logic [2:0]  len_q, len_d;
  logic [15:0] pv_q, pv_d;
  logic        inv_q, inv_d;
  logic [31:0] bt_q, bt_d;
  logic [15:0] ut_q, ut_d;
  stop_e       stop_q, stop_d;

  logic        n_halted, n_inv, c_inv;
  logic [2:0]  n_left, n_len, nbytes;
  logic [15:0] n_pv, n_ut, elem_val;
  logic [31:0] n_bt;
  logic [32:0] bsum;
  stop_e       n_stop;
  logic        unit_v, term_v, elem_v;
  result_t     elem_r, sum_r;
  logic        nul_b;

  always_comb begin
    n_halted = halted_q;
    n_left   = left_q;
    n_len    = len_q;
    n_pv     = pv_q;
    n_inv    = inv_q;
    n_stop   = stop_q;
    unit_v   = 1'b0;
    term_v   = 1'b0;
    elem_val = '0;
    nbytes   = '0;
    c_inv    = 1'b0;
    nul_b    = cfg_i.stop_at_nul && (data_byte_i == 8'h00);

    if (!halted_q) begin
      if (left_q == 3'd0) begin
        if (ut_q >= cfg_i.unit_capacity) begin
          n_halted = 1'b1;
          n_stop   = STOP_CAPACITY;
        end else if (nul_b) begin
          n_halted = 1'b1;
          n_stop   = STOP_NUL;
          term_v   = 1'b1;
        end else if (!data_byte_i[7]) begin
          unit_v   = 1'b1;
          elem_val = {8'h00, data_byte_i};
          nbytes   = 3'd1;
        end else if (data_byte_i < 8'hE0) begin
          n_len  = 3'd2;
          n_left = 3'd1;
          n_pv   = {11'b0, data_byte_i[4:0]};
          n_inv  = 1'b0;
        end else if (data_byte_i < 8'hF0) begin
          n_len  = 3'd3;
          n_left = 3'd2;
          n_pv   = {12'b0, data_byte_i[3:0]};
          n_inv  = 1'b0;
        end else if (data_byte_i < 8'hFE) begin
          n_len  = (data_byte_i < 8'hF8) ? 3'd4 : (data_byte_i < 8'hFC) ? 3'd5 : 3'd6;
          n_left = n_len - 3'd1;
          n_pv   = '0;
          n_inv  = 1'b1;
        end else begin
          unit_v   = 1'b1;
          elem_val = BAD_UNIT;
          nbytes   = 3'd1;
        end
      end else if (nul_b) begin
        n_halted = 1'b1;
        n_stop   = STOP_INCOMPLETE;
        n_left   = 3'd0;
        term_v   = (ut_q < cfg_i.unit_capacity);
      end else begin
        c_inv  = inv_q | (data_byte_i[7:6] != 2'b10);
        n_inv  = c_inv;
        n_pv   = {pv_q[9:0], data_byte_i[5:0]};
        n_left = left_q - 3'd1;
        if (left_q == 3'd1) begin
          unit_v   = 1'b1;
          elem_val = c_inv ? BAD_UNIT : n_pv;
          nbytes   = len_q;
        end
      end
    end

    bsum = {1'b0, bt_q} + {30'b0, nbytes};
    n_bt = bt_q;
    n_ut = ut_q;
    if (unit_v) begin
      n_bt = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
      n_ut = (ut_q != 16'hFFFF) ? ut_q + 16'd1 : ut_q;
    end
    if (last_byte_i && !n_halted && (n_left != 3'd0)) begin
      n_stop = STOP_INCOMPLETE;
    end

    elem_v = unit_v | term_v;

    elem_r                = '0;
    elem_r.code_unit      = elem_val;
    elem_r.stop_reason    = STOP_CLEAN;
    elem_r.run_end        = !last_byte_i;

    sum_r                 = '0;
    sum_r.is_summary      = 1'b1;
    sum_r.stop_reason     = n_stop;
    sum_r.bytes_consumed  = n_bt;
    sum_r.units_written   = n_ut;
    sum_r.run_end         = 1'b1;

    push_o.r0    = elem_v ? elem_r : sum_r;
    push_o.r1    = sum_r;
    push_o.count = {1'b0, elem_v} + {1'b0, last_byte_i};
    if (!step_i) begin
      push_o.count = 2'd0;
    end

    if (last_byte_i) begin
      halted_d = 1'b0;
      left_d   = '0;
      len_d    = '0;
      pv_d     = '0;
      inv_d    = 1'b0;
      bt_d     = '0;
      ut_d     = '0;
      stop_d   = STOP_CLEAN;
    end else begin
      halted_d = n_halted;
      left_d   = n_left;
      len_d    = n_len;
      pv_d     = n_pv;
      inv_d    = n_inv;
      bt_d     = n_bt;
      ut_d     = n_ut;
      stop_d   = n_stop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      left_q   <= '0;
      len_q    <= '0;
      pv_q     <= '0;
      inv_q    <= 1'b0;
      bt_q     <= '0;
      ut_q     <= '0;
      stop_q   <= STOP_CLEAN;
    end else if (step_i) begin
      halted_q <= halted_d;
      left_q   <= left_d;
      len_q    <= len_d;
      pv_q     <= pv_d;
      inv_q    <= inv_d;
      bt_q     <= bt_d;
      ut_q     <= ut_d;
      stop_q   <= stop_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/u8u16_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_queue
// Result queue: takes up to two results a cycle, hands out one while ready.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  u8u16_pkg::push_t      push_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  wire                   ready_i,
  output u8u16_pkg::result_t    head_o
);
  import u8u16_pkg::*;

  localparam logic [QPTR_W:0] ROOM_LEVEL = (QPTR_W+1)'(QUEUE_DEPTH - 2);

  result_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              pop;

  assign wr_nxt  = wr_q + QPTR_W'(1);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign space_o = (cnt_q <= ROOM_LEVEL);
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = wr_q + QPTR_W'(push_i.count);
    rd_d  = pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(push_i.count) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/utf8_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches the byte and result channels of the UTF-8 to UTF-16 decoder and
// the register write port. Every accepted byte is decoded by a local model
// into the results it should cause; every accepted result is compared field
// by field with the oldest of those. Mismatches are counted for the top.
// ----------------------------------------------------------------------------

module utf8_decode_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  u8u16_byte_if                            in_mon,
  u8u16_result_if                          out_mon,
  input  logic                             cfg_we_i,
  input  logic [u8u16_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [u8u16_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                               err_count_o,
  output int                               pending_o
);
  import u8u16_pkg::*;

  logic        nul_mode;
  logic [15:0] capacity;

  logic        halted;
  logic [2:0]  bytes_left;
  logic [2:0]  seq_len;
  logic [15:0] partial;
  logic        seq_bad;
  logic [31:0] byte_total;
  logic [15:0] unit_total;
  stop_e       stop_code;

  result_t     expected_results[$];
  result_t     want;

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_val));
  endtask

  task automatic clear_buffer();
    halted     = 1'b0;
    bytes_left = '0;
    seq_len    = '0;
    partial    = '0;
    seq_bad    = 1'b0;
    byte_total = '0;
    unit_total = '0;
    stop_code  = STOP_CLEAN;
  endtask

  task automatic count_unit(input logic [31:0] nbytes);
    byte_total = (byte_total > 32'hFFFF_FFFF - nbytes) ? 32'hFFFF_FFFF
                                                      : byte_total + nbytes;
    if (unit_total != 16'hFFFF)
      unit_total = unit_total + 16'd1;
  endtask

  function automatic result_t make_result(input logic [15:0] unit,
                                          input logic summary);
    result_t r;
    r = '0;
    r.code_unit  = unit;
    r.is_summary = summary;
    if (summary) begin
      r.stop_reason    = stop_code;
      r.bytes_consumed = byte_total;
      r.units_written  = unit_total;
    end
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic last);
    result_t r[2];
    int      n;
    n = 0;
    if (!halted) begin
      if (bytes_left == 0) begin
        if (unit_total >= capacity) begin
          halted    = 1'b1;
          stop_code = STOP_CAPACITY;
        end else if (nul_mode && b == 8'h00) begin
          halted    = 1'b1;
          stop_code = STOP_NUL;
          r[n] = make_result(16'h0000, 1'b0);
          n++;
        end else if (b < 8'h80) begin
          count_unit(1);
          r[n] = make_result({8'h00, b}, 1'b0);
          n++;
        end else if (b < 8'hE0) begin
          seq_len    = 3'd2;
          bytes_left = 3'd1;
          partial    = {11'd0, b[4:0]};
          seq_bad    = 1'b0;
        end else if (b < 8'hF0) begin
          seq_len    = 3'd3;
          bytes_left = 3'd2;
          partial    = {12'd0, b[3:0]};
          seq_bad    = 1'b0;
        end else if (b < 8'hFE) begin
          seq_len    = (b < 8'hF8) ? 3'd4 : (b < 8'hFC) ? 3'd5 : 3'd6;
          bytes_left = seq_len - 3'd1;
          partial    = '0;
          seq_bad    = 1'b1;
        end else begin
          count_unit(1);
          r[n] = make_result(BAD_UNIT, 1'b0);
          n++;
        end
      end else if (nul_mode && b == 8'h00) begin
        // NUL inside a sequence: sequence dropped, terminator if room
        halted     = 1'b1;
        stop_code  = STOP_INCOMPLETE;
        bytes_left = '0;
        if (unit_total < capacity) begin
          r[n] = make_result(16'h0000, 1'b0);
          n++;
        end
      end else begin
        if (b[7:6] != 2'b10)
          seq_bad = 1'b1;
        partial    = {partial[9:0], b[5:0]};
        bytes_left = bytes_left - 3'd1;
        if (bytes_left == 0) begin
          count_unit({29'd0, seq_len});
          r[n] = make_result(seq_bad ? BAD_UNIT : partial, 1'b0);
          n++;
        end
      end
    end
    if (last) begin
      if (!halted && bytes_left != 0)
        stop_code = STOP_INCOMPLETE;
      r[n] = make_result(16'h0000, 1'b1);
      n++;
      clear_buffer();
    end
    if (n > 0)
      r[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++)
      expected_results.push_back(r[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      clear_buffer();
      nul_mode    = 1'b0;
      capacity    = 16'hFFFF;
      err_count_o = 0;
      pending_o  <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result, code unit 0x%0h", out_mon.code_unit));
        end else begin
          want = expected_results.pop_front();
          check_field("code_unit", out_mon.code_unit, want.code_unit);
          check_field("is_summary", out_mon.is_summary, want.is_summary);
          check_field("stop_reason", out_mon.stop_reason, want.stop_reason);
          check_field("bytes_consumed", out_mon.bytes_consumed, want.bytes_consumed);
          check_field("units_written", out_mon.units_written, want.units_written);
          check_field("run_end", out_mon.run_end, want.run_end);
        end
      end
      if (in_mon.valid && in_mon.ready)
        decode_byte(in_mon.data_byte, in_mon.last_byte);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STOP_AT_NUL:   nul_mode = cfg_data_i[0];
          CFG_UNIT_CAPACITY: capacity = cfg_data_i[15:0];
          default: ;
        endcase
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== tb/utf8_to_utf16_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_tb
// Drives UTF-8 buffers into the decoder under several register settings:
// a directed set of sequences and stop cases, then random buffers built
// mostly from well-formed sequences with broken and noise bytes mixed in.
// Both channels idle in random bursts; one long receiver hold-off fills
// the block. A checker module predicts and compares every result.
// ----------------------------------------------------------------------------

module utf8_to_utf16_decoder_tb;
  import u8u16_pkg::*;

  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int RANDOM_PHASES    = 10;
  localparam int PHASE_BYTES      = 160;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int         err_count;
  int         pending;
  int         bytes_sent;
  bit         idle_on;
  bit         long_hold;
  logic [7:0] frame_bytes[$];

  u8u16_byte_if   byte_ch();
  u8u16_result_if unit_ch();

  utf8_to_utf16_decoder DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (byte_ch),
    .out_o      (unit_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  utf8_decode_checker decode_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (byte_ch),
    .out_mon     (unit_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    forever begin
      if (long_hold) begin
        unit_ch.ready <= 1'b0;
        long_hold = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        unit_ch.ready <= 1'b0;
        hold = $urandom_range(1, 4);
        repeat (hold) @(posedge clk);
      end else begin
        unit_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      byte_ch.valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic nul, input logic [15:0] cap);
    write_reg(CFG_STOP_AT_NUL, {15'd0, nul});
    write_reg(CFG_UNIT_CAPACITY, cap);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom())};
  endfunction

  task automatic add_random_seq();
    int         kind;
    logic [7:0] lead;
    int         conts;
    kind = $urandom_range(0, 11);
    case (kind)
      0, 1, 2, 3: begin
        frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'h00
                                                          : 8'($urandom_range(1, 127)));
      end
      4, 5: begin
        frame_bytes.push_back(8'($urandom_range(8'h80, 8'hDF)));
        frame_bytes.push_back(cont_byte());
      end
      6, 7: begin
        frame_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        frame_bytes.push_back(cont_byte());
        frame_bytes.push_back(cont_byte());
      end
      8: begin
        lead  = 8'($urandom_range(8'hF0, 8'hFD));
        conts = (lead < 8'hF8) ? 3 : (lead < 8'hFC) ? 4 : 5;
        frame_bytes.push_back(lead);
        repeat (conts) frame_bytes.push_back(cont_byte());
      end
      9: frame_bytes.push_back($urandom_range(0, 1) ? 8'hFE : 8'hFF);
      10: begin
        // lead followed by an arbitrary byte: often a bad continuation
        frame_bytes.push_back(8'($urandom_range(8'hC0, 8'hEF)));
        frame_bytes.push_back(8'($urandom()));
      end
      default: frame_bytes.push_back(8'($urandom()));
    endcase
  endtask

  task automatic make_random_frame();
    int n_seq;
    frame_bytes.delete();
    n_seq = $urandom_range(1, 8);
    repeat (n_seq) add_random_seq();
    if (frame_bytes.size() > 1 && $urandom_range(0, 7) == 0)
      void'(frame_bytes.pop_back());
  endtask

  initial begin
    int   start_count;
    bit   paused;
    logic nul;
    logic [15:0] cap;

    rst_n             <= 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    idle_on    = 1'b1;
    long_hold  = 1'b0;
    bytes_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: counted mode, full capacity
    frame_bytes = '{8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hFE, 8'hFF,
                    8'hC3, 8'h41};
    send_frame();
    frame_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h82};
    send_frame();
    drain();

    // NUL mode, capacity of two units
    set_mode(1'b1, 16'd2);
    frame_bytes = '{8'h41, 8'h00, 8'h42};
    send_frame();
    frame_bytes = '{8'h41, 8'h42, 8'h43};
    send_frame();
    frame_bytes = '{8'hC3, 8'h00};
    send_frame();
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       begin nul = 1'b0; cap = 16'd0;     end
        1:       begin nul = 1'b1; cap = 16'hFFFF;  end
        2:       begin nul = 1'b0; cap = 16'hFFFF;  end
        3:       begin nul = 1'b1; cap = 16'($urandom_range(1, 6)); end
        4:       begin nul = 1'b0; cap = 16'($urandom_range(1, 6)); end
        5:       begin nul = 1'b1; cap = 16'd0;     end
        default: begin
          nul = 1'($urandom());
          cap = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                            : 16'($urandom_range(4, 40));
        end
      endcase
      set_mode(nul, cap);
      if (phase == 2)
        long_hold = 1'b1;
      if (phase == RANDOM_PHASES - 1)
        idle_on = 1'b0;
      start_count = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - start_count < PHASE_BYTES) begin
        make_random_frame();
        send_frame();
        if (phase == 6 && !paused && bytes_sent - start_count > PHASE_BYTES / 2) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    if (err_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
